// ===== design/rte_pkg.sv =====
package rte_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RETRY_W  = 8;
  localparam int unsigned VARTERM_W = 16;
  localparam int unsigned IN_W     = 72;
  localparam int unsigned OUT_W    = 96;

  localparam logic [TIME_W-1:0]    TIMEOUT_MIN   = 32'd1000;
  localparam logic [VARTERM_W-1:0] VARTERM_RESET = 16'd1000;
  localparam logic [RETRY_W-1:0]   RETRY_MAX     = 8'd1;

  typedef struct packed {
    logic                 taken;
    logic [TIME_W-1:0]    srtt;
    logic [TIME_W-1:0]    rttvar;
    logic [VARTERM_W-1:0] min_var;
  } stage_t;

endpackage

// ===== design/rte_est.sv =====
module rte_est (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                a_vld,
  input  logic                                b_ready,
  input  logic [rte_pkg::TIME_W-1:0]          now_ms,
  input  logic [rte_pkg::TIME_W-1:0]          sent_ms,
  input  logic [rte_pkg::RETRY_W-1:0]         retry_count,
  input  logic [rte_pkg::VARTERM_W-1:0]       min_var,
  output logic                                b_vld,
  output rte_pkg::stage_t                     b_stage
);

  logic                          have_r;
  logic                          have_nxt;
  logic [rte_pkg::TIME_W-1:0]    srtt_r;
  logic [rte_pkg::TIME_W-1:0]    srtt_nxt;
  logic [rte_pkg::TIME_W-1:0]    rttvar_r;
  logic [rte_pkg::TIME_W-1:0]    rttvar_nxt;
  logic                          b_vld_r;
  logic                          b_vld_nxt;
  rte_pkg::stage_t               b_r;

  logic                          ok;
  logic                          load;
  logic [rte_pkg::TIME_W-1:0]    rtt;
  logic [rte_pkg::TIME_W-1:0]    diff;
  logic [rte_pkg::TIME_W+1:0]    var3;
  logic [rte_pkg::TIME_W+2:0]    srtt7;
  logic [rte_pkg::TIME_W:0]      v_sum;
  logic [rte_pkg::TIME_W:0]      s_sum;

  always_comb begin
    ok    = (retry_count <= rte_pkg::RETRY_MAX) && (now_ms >= sent_ms);
    load  = a_vld && b_ready;
    rtt   = now_ms - sent_ms;
    diff  = (srtt_r >= rtt) ? (srtt_r - rtt) : (rtt - srtt_r);
    var3  = {2'b00, rttvar_r} + {1'b0, rttvar_r, 1'b0};
    srtt7 = {srtt_r, 3'b000} - {3'b000, srtt_r};
    v_sum = {1'b0, var3[rte_pkg::TIME_W+1:2]} + {3'b000, diff[rte_pkg::TIME_W-1:2]};
    s_sum = {1'b0, srtt7[rte_pkg::TIME_W+2:3]} + {4'b0000, rtt[rte_pkg::TIME_W-1:3]};

    have_nxt   = have_r;
    srtt_nxt   = srtt_r;
    rttvar_nxt = rttvar_r;
    if (ok) begin
      have_nxt = 1'b1;
      if (!have_r) begin
        srtt_nxt   = rtt;
        rttvar_nxt = {1'b0, rtt[rte_pkg::TIME_W-1:1]};
      end else begin
        srtt_nxt   = s_sum[rte_pkg::TIME_W-1:0];
        rttvar_nxt = v_sum[rte_pkg::TIME_W-1:0];
      end
    end

    b_vld_nxt = b_ready ? a_vld : b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r   <= 1'b0;
      srtt_r   <= '0;
      rttvar_r <= '0;
      b_vld_r  <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
      if (load) begin
        have_r   <= have_nxt;
        srtt_r   <= srtt_nxt;
        rttvar_r <= rttvar_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_r.taken   <= ok;
      b_r.srtt    <= srtt_nxt;
      b_r.rttvar  <= rttvar_nxt;
      b_r.min_var <= min_var;
    end
  end

  assign b_vld   = b_vld_r;
  assign b_stage = b_r;

  a_taken_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r && b_r.taken |-> have_r)
    else $error("taken sample without estimator history");

  a_state_matches_stage: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (b_r.srtt == srtt_r) && (b_r.rttvar == rttvar_r))
    else $error("stage copy disagrees with estimator state");

endmodule

// ===== design/rte_rto.sv =====
module rte_rto (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            b_vld,
  input  rte_pkg::stage_t                 b_stage,
  input  logic                            out_tready,
  output logic                            slot_ready,
  output logic                            out_vld,
  output logic                            taken,
  output logic [rte_pkg::TIME_W-1:0]      timeout_ms,
  output logic [rte_pkg::TIME_W-1:0]      smoothed_rtt,
  output logic [rte_pkg::TIME_W-1:0]      rtt_variation
);

  logic [rte_pkg::TIME_W-1:0]    rto_r;
  logic [rte_pkg::TIME_W-1:0]    rto_nxt;
  logic                          out_vld_r;
  logic                          out_vld_nxt;
  logic                          taken_r;
  logic [rte_pkg::TIME_W-1:0]    timeout_r;
  logic [rte_pkg::TIME_W-1:0]    srtt_r;
  logic [rte_pkg::TIME_W-1:0]    rttvar_r;

  logic                          load;
  logic [rte_pkg::TIME_W+1:0]    var4;
  logic [rte_pkg::TIME_W+1:0]    floor_term;
  logic [rte_pkg::TIME_W+1:0]    term;
  logic [rte_pkg::TIME_W+2:0]    sum;
  logic [rte_pkg::TIME_W-1:0]    sat;

  always_comb begin
    slot_ready = !out_vld_r || out_tready;
    load       = b_vld && slot_ready;
    var4       = {b_stage.rttvar, 2'b00};
    floor_term = {{(rte_pkg::TIME_W+2-rte_pkg::VARTERM_W){1'b0}}, b_stage.min_var};
    term       = (var4 > floor_term) ? var4 : floor_term;
    sum        = {1'b0, term} + {3'b000, b_stage.srtt};
    if (sum[rte_pkg::TIME_W+2:rte_pkg::TIME_W] != 3'b000) begin
      sat = '1;
    end else if (sum[rte_pkg::TIME_W-1:0] < rte_pkg::TIMEOUT_MIN) begin
      sat = rte_pkg::TIMEOUT_MIN;
    end else begin
      sat = sum[rte_pkg::TIME_W-1:0];
    end
    rto_nxt     = b_stage.taken ? sat : rto_r;
    out_vld_nxt = slot_ready ? b_vld : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rto_r     <= {{(rte_pkg::TIME_W-rte_pkg::VARTERM_W){1'b0}}, rte_pkg::VARTERM_RESET};
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (load) begin
        rto_r <= rto_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      taken_r   <= b_stage.taken;
      timeout_r <= rto_nxt;
      srtt_r    <= b_stage.srtt;
      rttvar_r  <= b_stage.rttvar;
    end
  end

  assign out_vld       = out_vld_r;
  assign taken         = taken_r;
  assign timeout_ms    = timeout_r;
  assign smoothed_rtt  = srtt_r;
  assign rtt_variation = rttvar_r;

  a_timeout_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> timeout_r >= rte_pkg::TIMEOUT_MIN)
    else $error("timeout below minimum");

  a_skip_holds_rto: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !taken_r |-> timeout_r == rto_r)
    else $error("skipped sample changed timeout");

  a_rto_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> rto_r == timeout_r)
    else $error("timeout state and result disagree");

endmodule

// ===== design/retransmit_timeout_estimator_top.sv =====
// Channel  Direction  Handshake                Payload
// in_      slave      in_tvalid / in_tready    in_tdata: now_ms, sent_ms, retry_count
// out_     master     out_tvalid / out_tready  out_tdata: timeout_ms, srtt, rttvar;
//                                              out_tuser: sample_taken
// cfg_     write      cfg_wr_en                cfg_wr_data: min_variance_term
//
// Three register stages: input, estimator update, timeout; one result per
// transfer, one transfer per cycle while out_tready is high.
// The estimator state loop closes in the update stage.
// Reset (rst_n low, synchronous) empties all stages and sets the timeout to 1000.
// A full stage holds while the stage after it holds; in_tready drops only when
// every stage is full and out_tready is low.
module retransmit_timeout_estimator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rte_pkg::IN_W-1:0]         in_tdata,   // now_ms, sent_ms, retry_count
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rte_pkg::OUT_W-1:0]        out_tdata,  // timeout_ms, smoothed_rtt, rtt_variation
  output logic                             out_tuser,  // sample_taken
  input  logic                             cfg_wr_en,
  input  logic [rte_pkg::VARTERM_W-1:0]    cfg_wr_data
);

  logic [rte_pkg::VARTERM_W-1:0]  min_var_r;
  logic                           a_vld_r;
  logic                           a_vld_nxt;
  logic [rte_pkg::TIME_W-1:0]     now_r;
  logic [rte_pkg::TIME_W-1:0]     sent_r;
  logic [rte_pkg::RETRY_W-1:0]    retry_r;

  logic                           b_vld;
  logic                           b_ready;
  rte_pkg::stage_t                b_stage;
  logic                           slot_ready;
  logic [rte_pkg::TIME_W-1:0]     timeout_ms;
  logic [rte_pkg::TIME_W-1:0]     smoothed_rtt;
  logic [rte_pkg::TIME_W-1:0]     rtt_variation;

  always_comb begin
    b_ready   = !b_vld || slot_ready;
    in_tready = !a_vld_r || b_ready;
    a_vld_nxt = in_tready ? in_tvalid : a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      min_var_r <= rte_pkg::VARTERM_RESET;
    end else begin
      a_vld_r <= a_vld_nxt;
      if (cfg_wr_en) begin
        min_var_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r   <= in_tdata[31:0];
      sent_r  <= in_tdata[63:32];
      retry_r <= in_tdata[71:64];
    end
  end

  rte_est u_est (
    .clk         (clk),
    .rst_n       (rst_n),
    .a_vld       (a_vld_r),
    .b_ready     (b_ready),
    .now_ms      (now_r),
    .sent_ms     (sent_r),
    .retry_count (retry_r),
    .min_var     (min_var_r),
    .b_vld       (b_vld),
    .b_stage     (b_stage)
  );

  rte_rto u_rto (
    .clk           (clk),
    .rst_n         (rst_n),
    .b_vld         (b_vld),
    .b_stage       (b_stage),
    .out_tready    (out_tready),
    .slot_ready    (slot_ready),
    .out_vld       (out_tvalid),
    .taken         (out_tuser),
    .timeout_ms    (timeout_ms),
    .smoothed_rtt  (smoothed_rtt),
    .rtt_variation (rtt_variation)
  );

  assign out_tdata = {rtt_variation, smoothed_rtt, timeout_ms};

endmodule
